@@ rtl/i2d_pkg.sv @@
// shared types and constants for the binary to decimal ascii converter
// no dependencies; imported by every module of the block
`default_nettype none

package i2d_pkg;

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;

    typedef enum logic [1:0] {
        DAB_IDLE,
        DAB_RUN,
        DAB_HOLD
    } dab_state_t;

    typedef enum logic [1:0] {
        EMT_IDLE,
        EMT_SIGN,
        EMT_DIGITS
    } emt_state_t;

    // handoff status from the shifter to the character sequencer
    typedef struct packed {
        logic valid;
        logic negative;
    } i2d_hand_t;

endpackage

`default_nettype wire

@@ rtl/i2d_dabble.sv @@
// bit-serial binary to bcd shifter (shift and add-3), one input bit per cycle
// depends on i2d_pkg
`default_nettype none

module i2d_dabble
    import i2d_pkg::*;
#(
    parameter int WORD_BITS  = 64,
    parameter int NUM_DIGITS = 20
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic                      negative,
    input  wire logic [WORD_BITS-1:0]      magnitude,
    input  wire logic                      take,
    output logic                           idle,
    output i2d_hand_t                      hand,
    output logic [4*NUM_DIGITS-1:0]        bcd
);

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(WORD_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    dab_state_t             state_reg, state_next;
    logic [WORD_BITS-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   neg_reg, neg_next;
    logic [BCD_W-1:0]       adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            dig = bcd_reg[4*d +: 4];
            adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DAB_IDLE: if (start) state_next = DAB_RUN;
            DAB_RUN:  if (count_reg == '0) state_next = DAB_HOLD;
            DAB_HOLD: if (take) state_next = DAB_IDLE;
            default:  state_next = DAB_IDLE;
        endcase
    end

    always_comb begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        case (state_reg)
            DAB_IDLE: begin
                if (start) begin
                    bin_next   = magnitude;
                    bcd_next   = '0;
                    count_next = CNT_INIT;
                    neg_next   = negative;
                end
            end
            DAB_RUN: begin
                {bcd_next, bin_next} = {adj[BCD_W-2:0], bin_reg, 1'b0};
                count_next = count_reg - CNT_ONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DAB_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        count_reg <= count_next;
        neg_reg   <= neg_next;
    end

    assign idle          = (state_reg == DAB_IDLE);
    assign hand.valid    = (state_reg == DAB_HOLD);
    assign hand.negative = neg_reg;
    assign bcd           = bcd_reg;

endmodule

`default_nettype wire

@@ rtl/i2d_emit.sv @@
// character sequencer: skips leading zeros, sends sign and digits, one per transfer
// depends on i2d_pkg
`default_nettype none

module i2d_emit
    import i2d_pkg::*;
#(
    parameter int NUM_DIGITS = 20
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire i2d_hand_t                 hand,
    input  wire logic [4*NUM_DIGITS-1:0]   bcd,
    output logic                           take,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [5:0]                     m_character,
    output logic                           m_last
);

    localparam int BCD_W  = 4 * NUM_DIGITS;
    localparam int LEFT_W = $clog2(NUM_DIGITS + 1);
    localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_ONE  = LEFT_W'(1);

    emt_state_t          state_reg, state_next;
    logic [BCD_W-1:0]    digits_reg, digits_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                started_reg, started_next;
    logic                valid_reg, valid_next;
    logic [5:0]          char_reg, char_next;
    logic                last_reg, last_next;
    logic                out_free;
    logic [3:0]          top_digit;
    logic                skip;

    assign out_free  = !valid_reg || m_ready;
    assign top_digit = digits_reg[BCD_W-1 -: 4];
    // a leading zero is dropped unless it is the only digit
    assign skip      = !started_reg && (top_digit == 4'd0) && (left_reg != LEFT_ONE);
    assign take      = (state_reg == EMT_IDLE) && hand.valid;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EMT_IDLE: begin
                if (hand.valid) state_next = hand.negative ? EMT_SIGN : EMT_DIGITS;
            end
            EMT_SIGN: if (out_free) state_next = EMT_DIGITS;
            EMT_DIGITS: begin
                if (!skip && out_free && left_reg == LEFT_ONE) state_next = EMT_IDLE;
            end
            default: state_next = EMT_IDLE;
        endcase
    end

    always_comb begin
        digits_next  = digits_reg;
        left_next    = left_reg;
        started_next = started_reg;
        valid_next   = valid_reg && !m_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            EMT_IDLE: begin
                if (hand.valid) begin
                    digits_next  = bcd;
                    left_next    = LEFT_INIT;
                    started_next = 1'b0;
                end
            end
            EMT_SIGN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                end
            end
            EMT_DIGITS: begin
                if (skip) begin
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    left_next   = left_reg - LEFT_ONE;
                end else if (out_free) begin
                    valid_next   = 1'b1;
                    char_next    = CHAR_ZERO + {2'b00, top_digit};
                    last_next    = (left_reg == LEFT_ONE);
                    started_next = 1'b1;
                    digits_next  = {digits_reg[BCD_W-5:0], 4'd0};
                    left_next    = left_reg - LEFT_ONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EMT_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        digits_reg  <= digits_next;
        left_reg    <= left_next;
        started_reg <= started_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_valid     = valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

`default_nettype wire

@@ rtl/int64_to_decimal_ascii.sv @@
// Converts one word per input transfer into its decimal text, one ASCII character per
// output transfer, most significant first, with a minus sign for negative signed words
// and the last flag on the final digit. A bit-serial shift-and-add-3 converter first
// builds the BCD digits; the character sequencer then steps over each leading zero and
// sends each character (at most NUM_DIGITS digits plus one for the sign), stalled only by
// m_ready. The next word is accepted as soon as the previous digits have moved into the
// sequencer, so the converter can work on a new word while the sequencer is still
// sending the text of the word before it.
// Depends on i2d_pkg, i2d_dabble and i2d_emit.
`default_nettype none

module int64_to_decimal_ascii
    import i2d_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [63:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_character,
    output logic             m_last
);

    // enough decimal digits for 2^WORD_BITS - 1
    localparam int NUM_DIGITS = (WORD_BITS * 30103) / 100000 + 1;

    logic [WORD_BITS-1:0]    word;
    logic                    negative;
    logic [WORD_BITS-1:0]    magnitude;
    logic                    dab_idle;
    logic                    take;
    i2d_hand_t               hand;
    logic [4*NUM_DIGITS-1:0] bcd;

    assign word      = s_value[WORD_BITS-1:0];
    assign negative  = s_command && word[WORD_BITS-1];
    // the most negative word wraps back to itself, which is its exact magnitude
    assign magnitude = negative ? (~word + WORD_BITS'(1)) : word;
    assign s_ready   = dab_idle;

    i2d_dabble #(
        .WORD_BITS  (WORD_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && dab_idle),
        .negative  (negative),
        .magnitude (magnitude),
        .take      (take),
        .idle      (dab_idle),
        .hand      (hand),
        .bcd       (bcd)
    );

    i2d_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hand        (hand),
        .bcd         (bcd),
        .take        (take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

`default_nettype wire

@@ rtl/i2d_checker.sv @@
// port-level checks for int64_to_decimal_ascii, attached by bind
// depends on i2d_pkg and the top level's ports
`default_nettype none

module i2d_checker
    import i2d_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [5:0] m_character,
    input wire logic       m_last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid && !m_ready |=> m_valid && $stable(m_character) && $stable(m_last))
        else $error("result changed while stalled");

    // only a minus sign or a decimal digit is ever sent
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid |-> (m_character == CHAR_MINUS) ||
                    (m_character >= CHAR_ZERO && m_character <= CHAR_ZERO + 6'd9))
        else $error("character out of range");

    // the sign always has digits after it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid && m_character == CHAR_MINUS |-> !m_last)
        else $error("minus sign flagged last");

    // reset leaves no result pending
    assert property (@(posedge clk)
        !rst_n |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind int64_to_decimal_ascii i2d_checker u_i2d_checker (
    .clk         (aclk),
    .rst_n       (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last      (m_last)
);

`default_nettype wire

@@ tb/sv/int64_to_decimal_ascii_tb.sv @@
// self-checking testbench for int64_to_decimal_ascii: directed table, then random words
// under changing backpressure, every output transfer checked against a literal text or a decimal text predictor
// depends on i2d_pkg and the int64_to_decimal_ascii rtl
`default_nettype none

module int64_to_decimal_ascii_tb
    import i2d_pkg::*;
();

    localparam logic CMD_UNSIGNED   = 1'b0;
    localparam logic CMD_SIGNED     = 1'b1;
    localparam int   MAX_DIGITS     = 20;
    localparam int   RAND_PER_PHASE = 149;
    localparam int   RX_HOLD_CYCLES = 400;
    localparam int   STALL_LIMIT    = 5000;
    localparam int   TAIL_CYCLES    = 200;
    localparam int   MAX_REPORTS    = 40;

    typedef struct packed {
        logic [5:0] ch;
        logic       last;
    } text_char_t;

    // empty text means the row is checked against the predictor
    typedef struct {
        logic        cmd;
        logic [63:0] word;
        string       text;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [63:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_character;
    logic        m_last;

    text_char_t  expected_text [$];
    int          err_count;
    int          send_idle;
    int          recv_idle;
    logic        rx_hold_req;
    int          stall_cycles;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_UNSIGNED, 64'd0,                   "0"},
        '{CMD_SIGNED,   64'd0,                   "0"},
        '{CMD_UNSIGNED, 64'd1,                   "1"},
        '{CMD_SIGNED,   64'd1,                   "1"},
        '{CMD_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, "18446744073709551615"},
        '{CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, "-1"},
        '{CMD_SIGNED,   64'h8000_0000_0000_0000, "-9223372036854775808"},
        '{CMD_UNSIGNED, 64'h8000_0000_0000_0000, "9223372036854775808"},
        '{CMD_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807"},
        '{CMD_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF, ""},
        '{CMD_UNSIGNED, 64'd9,                   ""},
        '{CMD_UNSIGNED, 64'd10,                  ""},
        '{CMD_UNSIGNED, 64'd99,                  ""},
        '{CMD_SIGNED,   64'd100,                 ""},
        '{CMD_UNSIGNED, 64'd10000000000000000000, ""},
        '{CMD_UNSIGNED, 64'd9999999999999999999, ""},
        '{CMD_SIGNED,   64'hFFFF_FFFF_FFFF_FFF6, ""},
        '{CMD_SIGNED,   64'h8000_0000_0000_0001, ""},
        '{CMD_UNSIGNED, 64'h0000_0000_FFFF_FFFF, ""},
        '{CMD_SIGNED,   64'h5555_5555_5555_5555, ""},
        '{CMD_SIGNED,   64'hAAAA_AAAA_AAAA_AAAA, ""},
        '{CMD_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA, ""}
    };

    int64_to_decimal_ascii u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch: %s", what);
        end
        err_count++;
    endtask

    // decimal text of one word, most significant character first
    function automatic void predict_text(input logic cmd, input logic [63:0] word);
        logic        negative;
        logic [63:0] mag;
        logic [3:0]  digits [MAX_DIGITS];
        int          nd;
        int          i;
        text_char_t  c;
        negative = (cmd == CMD_SIGNED) && word[63];
        mag = negative ? (~word + 64'd1) : word;
        nd = 0;
        do begin
            digits[nd] = 4'(mag % 64'd10);
            mag = mag / 64'd10;
            nd++;
        end while (mag != 64'd0 && nd < MAX_DIGITS);
        if (negative) begin
            c.ch = CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (i = nd - 1; i >= 0; i--) begin
            c.ch = CHAR_ZERO + 6'(digits[i]);
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endfunction

    function automatic void queue_literal_text(input string text);
        int         i;
        text_char_t c;
        for (i = 0; i < text.len(); i++) begin
            c.ch = 6'(text[i]);
            c.last = (i == text.len() - 1);
            expected_text.push_back(c);
        end
    endfunction

    function automatic logic [63:0] pick_word();
        logic [63:0] p;
        int          k;
        p = 64'd1;
        k = $urandom_range(19);
        case ($urandom_range(5))
            0: pick_word = {$urandom, $urandom};
            1: pick_word = 64'($urandom_range(999));
            2: begin
                // around a power of ten, where the digit count changes
                repeat (k) p = p * 64'd10;
                pick_word = p + 64'($urandom_range(2)) - 64'd1;
            end
            3: pick_word = -64'($urandom_range(1000, 1));
            4: pick_word = {$urandom, $urandom} >> $urandom_range(63);
            default: pick_word = 64'h8000_0000_0000_0000 ^ 64'($urandom_range(3))
                                 ^ ({64{$urandom_range(1) == 1}} & 64'h7FFF_FFFF_FFFF_FFFC);
        endcase
    endfunction

    // returns at the edge where the transfer happened
    task automatic send_word(input logic cmd, input logic [63:0] word, input string text);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (text.len() == 0) begin
            predict_text(cmd, word);
        end else begin
            queue_literal_text(text);
        end
    endtask

    // receiver ready, with an occasional long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        text_char_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected character %0d", m_character));
            end else begin
                exp_c = expected_text.pop_front();
                if (m_character !== exp_c.ch) begin
                    report_mismatch($sformatf("character %0d, expected %0d",
                                              m_character, exp_c.ch));
                end
                if (m_last !== exp_c.last) begin
                    report_mismatch($sformatf("last %b, expected %b on character %0d",
                                              m_last, exp_c.last, exp_c.ch));
                end
            end
        end
    end

    // cycles with no transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("int64_to_decimal_ascii verification failed");
            $finish;
        end
    end

    initial begin
        int r;
        int ph;
        int n;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_UNSIGNED;
        s_value      = 64'd0;
        err_count    = 0;
        send_idle    = 0;
        recv_idle    = 0;
        rx_hold_req  = 1'b0;
        stall_cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIR_ROWS; r++) begin
            send_word(dir_rows[r].cmd, dir_rows[r].word, dir_rows[r].text);
        end

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 16; recv_idle = 86; end
                1: begin send_idle = 86; recv_idle = 16; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 2 && n == 20) begin
                    // sender keeps offering while the receiver holds off
                    rx_hold_req = 1'b1;
                end
                if (ph == 1 && n == 60) begin
                    // sender pauses until every queued character has come out
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (expected_text.size() != 0);
                end
                send_word(1'($urandom_range(1)), pick_word(), "");
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_text.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("int64_to_decimal_ascii verification clean");
        end else begin
            $display("int64_to_decimal_ascii verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/i2d_pkg.sv
rtl/i2d_dabble.sv
rtl/i2d_emit.sv
rtl/int64_to_decimal_ascii.sv
rtl/i2d_checker.sv
tb/sv/int64_to_decimal_ascii_tb.sv
